>>> hw/rtl/dtsav_pkg.sv
// Package for the audio/video decode-timestamp interleaver.
// Holds transaction payload types, status and kind codes, and default sizes.
// No dependencies.
`default_nettype none
package dtsav_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_TIME_BITS   = 32;

	localparam logic       MODE_PUSH = 1'b0;
	localparam logic       MODE_POP  = 1'b1;

	localparam logic [1:0] KIND_AUDIO = 2'd0;
	localparam logic [1:0] KIND_VIDEO = 2'd1;

	localparam logic       OUT_AUDIO = 1'b0;
	localparam logic       OUT_VIDEO = 1'b1;

	localparam logic [2:0] STAT_PUSHED   = 3'd0;
	localparam logic [2:0] STAT_POPPED   = 3'd1;
	localparam logic [2:0] STAT_EMPTY    = 3'd2;
	localparam logic [2:0] STAT_OVERFLOW = 3'd3;
	localparam logic [2:0] STAT_IGNORED  = 3'd4;

	typedef struct packed {
		logic               mode;
		logic [1:0]         media_kind;
		logic signed [31:0] present_time_ms;
		logic signed [31:0] decode_time_ms;
		logic               is_key;
		logic [1:0]         prio_level;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               out_kind;
		logic signed [31:0] out_present_ms;
		logic signed [31:0] out_decode_ms;
		logic               out_key;
		logic [1:0]         out_prio;
	} rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/dtsav_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
// Depends on nothing; the payload type is given at instantiation.
`default_nettype none
interface dtsav_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dts_ordered_av_interleaver_core.sv
// Top level of the audio/video interleaver: two packet FIFOs in memories.
// Uses dtsav_pkg and dtsav_stream_if.
//
//  channel | modport | payload          | role
//  cmd     | sink    | dtsav_pkg::cmd_t | push a packet or request a pop
//  rsp     | source  | dtsav_pkg::rsp_t | one result per command
//
// A push writes the memory and loads the result register at the accepting
// edge. A pop enters the POP state while both head entries are registered
// from memory, then compared; the winner retires when the result slot frees.
// Reset clears pointers, fill counts and the result register; memory
// contents are left as they are. A stalled result holds in its register and
// a new command is still taken when the result is taken in the same cycle.
`default_nettype none
module dts_ordered_av_interleaver_core #(
	parameter int QUEUE_DEPTH = dtsav_pkg::DEF_QUEUE_DEPTH,
	parameter int TIME_BITS   = dtsav_pkg::DEF_TIME_BITS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	dtsav_stream_if.sink   cmd,
	dtsav_stream_if.source rsp
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = 2 * TIME_BITS + 3;
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [FW-1:0] FULL = FW'(QUEUE_DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_POP  = 1'b1;

	// entry layout: {present, decode, key/prio attribute}
	logic [EW-1:0] a_mem [QUEUE_DEPTH];
	logic [EW-1:0] v_mem [QUEUE_DEPTH];
	logic [EW-1:0] a_rd_s1, v_rd_s1;

	logic          state_q;
	logic [AW-1:0] a_head_q, a_tail_q, v_head_q, v_tail_q;
	logic [FW-1:0] a_fill_q, v_fill_q;
	logic          rsp_valid_q;
	dtsav_pkg::rsp_t rsp_q;

	logic          slot_free, cmd_fire;
	logic          push_a, push_v;
	logic [EW-1:0] wr_entry;
	logic signed [63:0] pts_ext, dts_ext;

	logic [TIME_BITS-1:0] a_dec, v_dec, w_pts, w_dec;
	logic [2:0]           w_attr;
	logic                 a_full, v_full, take_a, take_v;
	logic signed [63:0]   o_pts_ext, o_dts_ext;

	logic            rsp_load;
	dtsav_pkg::rsp_t rsp_d;

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && slot_free;
	assign cmd_fire  = cmd.valid && cmd.ready;

	assign a_full = (a_fill_q == FULL);
	assign v_full = (v_fill_q == FULL);

	assign pts_ext  = 64'(cmd.payload.present_time_ms);
	assign dts_ext  = 64'(cmd.payload.decode_time_ms);
	assign wr_entry = {pts_ext[TIME_BITS-1:0], dts_ext[TIME_BITS-1:0],
		cmd.payload.prio_level, cmd.payload.is_key};

	assign push_a = cmd_fire && (cmd.payload.mode == dtsav_pkg::MODE_PUSH)
		&& (cmd.payload.media_kind == dtsav_pkg::KIND_AUDIO) && !a_full;
	assign push_v = cmd_fire && (cmd.payload.mode == dtsav_pkg::MODE_PUSH)
		&& (cmd.payload.media_kind == dtsav_pkg::KIND_VIDEO) && !v_full;

	// head reads run every cycle; a pop uses the word read at its accepting edge
	always_ff @(posedge clk) begin
		if (push_a) begin
			a_mem[a_tail_q] <= wr_entry;
		end
		if (push_v) begin
			v_mem[v_tail_q] <= wr_entry;
		end
		a_rd_s1 <= a_mem[a_head_q];
		v_rd_s1 <= v_mem[v_head_q];
	end

	assign a_dec  = a_rd_s1[TIME_BITS+2:3];
	assign v_dec  = v_rd_s1[TIME_BITS+2:3];
	assign take_a = (a_fill_q != '0) &&
		((v_fill_q == '0) || ($signed(a_dec) <= $signed(v_dec)));
	assign take_v = !take_a && (v_fill_q != '0);

	always_comb begin
		if (take_a) begin
			w_pts  = a_rd_s1[EW-1:TIME_BITS+3];
			w_dec  = a_dec;
			w_attr = a_rd_s1[2:0];
		end else begin
			w_pts  = v_rd_s1[EW-1:TIME_BITS+3];
			w_dec  = v_dec;
			w_attr = v_rd_s1[2:0];
		end
	end

	assign o_pts_ext = 64'($signed(w_pts));
	assign o_dts_ext = 64'($signed(w_dec));

	assign rsp_load = (cmd_fire && (cmd.payload.mode == dtsav_pkg::MODE_PUSH))
		|| ((state_q == ST_POP) && slot_free);

	always_comb begin
		rsp_d = '0;
		if (state_q == ST_POP) begin
			if (take_a || take_v) begin
				rsp_d.status         = dtsav_pkg::STAT_POPPED;
				rsp_d.out_kind       = take_a ? dtsav_pkg::OUT_AUDIO
				                              : dtsav_pkg::OUT_VIDEO;
				rsp_d.out_present_ms = o_pts_ext[31:0];
				rsp_d.out_decode_ms  = o_dts_ext[31:0];
				rsp_d.out_key        = w_attr[0];
				rsp_d.out_prio       = w_attr[2:1];
			end else begin
				rsp_d.status = dtsav_pkg::STAT_EMPTY;
			end
		end else if (push_a || push_v) begin
			rsp_d.status = dtsav_pkg::STAT_PUSHED;
		end else if (cmd.payload.media_kind inside
			{dtsav_pkg::KIND_AUDIO, dtsav_pkg::KIND_VIDEO}) begin
			rsp_d.status = dtsav_pkg::STAT_OVERFLOW;
		end else begin
			rsp_d.status = dtsav_pkg::STAT_IGNORED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			a_head_q    <= '0;
			a_tail_q    <= '0;
			a_fill_q    <= '0;
			v_head_q    <= '0;
			v_tail_q    <= '0;
			v_fill_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp.ready);
			if (rsp_load) begin
				rsp_q <= rsp_d;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire && (cmd.payload.mode == dtsav_pkg::MODE_POP)) begin
						state_q <= ST_POP;
					end
					if (push_a) begin
						a_tail_q <= (a_tail_q == LAST) ? '0 : a_tail_q + 1'b1;
						a_fill_q <= a_fill_q + 1'b1;
					end
					if (push_v) begin
						v_tail_q <= (v_tail_q == LAST) ? '0 : v_tail_q + 1'b1;
						v_fill_q <= v_fill_q + 1'b1;
					end
				end
				ST_POP: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						// retire the winning head
						if (take_a) begin
							a_head_q <= (a_head_q == LAST) ? '0 : a_head_q + 1'b1;
							a_fill_q <= a_fill_q - 1'b1;
						end
						if (take_v) begin
							v_head_q <= (v_head_q == LAST) ? '0 : v_head_q + 1'b1;
							v_fill_q <= v_fill_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule
`default_nettype wire
